[src/hbs_pkg.sv]
// ============================================================================
// hbs_pkg - shared types and constants for the heightmap bilinear sampler
// Field widths, transaction codes and the control bundles passed between the
// coordinate front end, the height store and the interpolator.
// ============================================================================
package hbs_pkg;

   // default parameter values
   localparam int GRID_MAX_DEF     = 128;
   localparam int HEIGHT_WIDTH_DEF = 16;

   // fixed field widths
   localparam int CELLS_W    = 8;
   localparam int HALF_W     = 23;
   localparam int INV_W      = 32;
   localparam int IDX_W      = 15;
   localparam int HV_W       = 16;
   localparam int POS_W      = 24;
   localparam int OUT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // grid coordinate: (pos * inv_cell) >> SCALE_SHIFT keeps FRAC_BITS of fraction
   localparam int FRAC_BITS   = 12;
   localparam int SCALE_SHIFT = 20;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_CELLS = 2'd0,
      CSR_HALF_SIZE  = 2'd1,
      CSR_INV_CELL   = 2'd2
   } csr_index_type;

   // corner read order; bit 0 selects the next column, bit 1 the next row
   typedef enum logic [1:0] {
      CORNER_00 = 2'd0,
      CORNER_10 = 2'd1,
      CORNER_01 = 2'd2,
      CORNER_11 = 2'd3
   } corner_type;

   typedef struct packed {
      logic valid;
      logic is_write;
      logic wr_ok;
      logic empty;
   } hbs_ctl_type;

   typedef struct packed {
      logic       valid;
      corner_type corner;
      logic       empty;
   } hbs_tag_type;

endpackage

[src/heightmap_bilinear_sampler.sv]
// ============================================================================
// heightmap_bilinear_sampler - grid height store with bilinear lookup
// Top level: configuration registers, front end, height store, interpolator.
// ============================================================================
// Usage:
//   Raise start with the req_ fields; the transaction is taken on a clock edge
//   where start is high and busy is low. func = write stores req_height_value
//   at req_sample_index and returns nothing; func = query returns one height.
//   Each result appears on rsp_height for exactly one cycle with rsp_strobe
//   high. The receiver cannot stall; results leave in transaction order.
//   Throughput: a write every cycle while no query holds the RAM port. The single
//   port of the height RAM is the limit: one access per write, one per cell corner.
//   busy rises only while the RAM port is occupied and the front pipeline has
//   backed up behind it.
//   csr_we writes register csr_index (grid_cells, half_size, inv_cell) on the
//   clock edge; write only while no transaction is in flight.
//   Reset (synchronous) clears the pipeline and registers; the RAM is not
//   cleared and an entry must be written before any query reads it.
// ============================================================================
module heightmap_bilinear_sampler import hbs_pkg::*; #(
   parameter int GRID_MAX     = GRID_MAX_DEF,
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_func,
   input  logic [IDX_W-1:0]        req_sample_index,
   input  logic signed [HV_W-1:0]  req_height_value,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_z,
   output logic                    rsp_strobe,
   output logic signed [OUT_W-1:0] rsp_height,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH  = (GRID_MAX + 1) * (GRID_MAX + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int V_W    = $clog2(GRID_MAX + 2);
   localparam int TX_W   = FRAC_BITS + 1;

   logic [CELLS_W-1:0] grid_cells_ff;
   logic [HALF_W-1:0]  half_size_ff;
   logic [INV_W-1:0]   inv_cell_ff;

   hbs_ctl_type             item_ctl;
   logic [ADDR_W-1:0]       item_addr;
   logic [HEIGHT_WIDTH-1:0] item_wdata;
   logic [V_W-1:0]          item_step;
   logic [TX_W-1:0]         item_tx, item_tz;
   logic                    item_ready;
   hbs_tag_type             rd_tag;
   logic [HEIGHT_WIDTH-1:0] rd_data;
   logic [TX_W-1:0]         rd_tx, rd_tz;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cells_ff <= '0;
         half_size_ff  <= '0;
         inv_cell_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_CELLS: grid_cells_ff <= csr_wdata[CELLS_W-1:0];
            CSR_HALF_SIZE:  half_size_ff  <= csr_wdata[HALF_W-1:0];
            CSR_INV_CELL:   inv_cell_ff   <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   hbs_coord #(
      .GRID_MAX     (GRID_MAX),
      .HEIGHT_WIDTH (HEIGHT_WIDTH)
   ) u_coord (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_sample_index (req_sample_index),
      .req_height_value (req_height_value),
      .req_pos_x        (req_pos_x),
      .req_pos_z        (req_pos_z),
      .grid_cells       (grid_cells_ff),
      .half_size        (half_size_ff),
      .inv_cell         (inv_cell_ff),
      .item_ready       (item_ready),
      .item_ctl         (item_ctl),
      .item_addr        (item_addr),
      .item_wdata       (item_wdata),
      .item_step        (item_step),
      .item_tx          (item_tx),
      .item_tz          (item_tz)
   );

   hbs_store #(
      .GRID_MAX     (GRID_MAX),
      .HEIGHT_WIDTH (HEIGHT_WIDTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .item_ctl   (item_ctl),
      .item_addr  (item_addr),
      .item_wdata (item_wdata),
      .item_step  (item_step),
      .item_tx    (item_tx),
      .item_tz    (item_tz),
      .item_ready (item_ready),
      .rd_tag     (rd_tag),
      .rd_data    (rd_data),
      .rd_tx      (rd_tx),
      .rd_tz      (rd_tz)
   );

   hbs_lerp #(
      .HEIGHT_WIDTH (HEIGHT_WIDTH)
   ) u_lerp (
      .clock      (clock),
      .reset      (reset),
      .rd_tag     (rd_tag),
      .rd_data    (rd_data),
      .rd_tx      (rd_tx),
      .rd_tz      (rd_tz),
      .rsp_strobe (rsp_strobe),
      .rsp_height (rsp_height)
   );

endmodule

[src/hbs_coord.sv]
// ============================================================================
// hbs_coord - coordinate front end
// Four-stage pipeline: offset and clamp, scale multiply, cell/fraction split,
// row-major base address. Stalls back from the height store.
// ============================================================================
module hbs_coord import hbs_pkg::*; #(
   parameter int GRID_MAX     = GRID_MAX_DEF,
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [IDX_W-1:0]              req_sample_index,
   input  logic signed [HV_W-1:0]        req_height_value,
   input  logic signed [POS_W-1:0]       req_pos_x,
   input  logic signed [POS_W-1:0]       req_pos_z,
   input  logic [CELLS_W-1:0]            grid_cells,
   input  logic [HALF_W-1:0]             half_size,
   input  logic [INV_W-1:0]              inv_cell,
   input  logic                          item_ready,
   output hbs_ctl_type                   item_ctl,
   output logic [$clog2((GRID_MAX+1)*(GRID_MAX+1))-1:0] item_addr,
   output logic [HEIGHT_WIDTH-1:0]       item_wdata,
   output logic [$clog2(GRID_MAX+2)-1:0] item_step,
   output logic [FRAC_BITS:0]            item_tx,
   output logic [FRAC_BITS:0]            item_tz
);

   localparam int DEPTH     = (GRID_MAX + 1) * (GRID_MAX + 1);
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int N_W       = $clog2(GRID_MAX + 1);
   localparam int V_W       = $clog2(GRID_MAX + 2);
   localparam int P_W       = POS_W + 1;
   localparam int PROD_W    = POS_W + INV_W;
   localparam int GFULL_W   = PROD_W - SCALE_SHIFT;
   localparam int G_W       = N_W + FRAC_BITS;
   localparam int TX_W      = FRAC_BITS + 1;
   localparam int SPLIT_W   = N_W + TX_W;

   // clamp to [0, n], then split into cell index (max n-1) and fraction (0..4096)
   function automatic logic [SPLIT_W-1:0] split_coord(input logic [PROD_W-1:0] prod,
                                                      input logic [N_W-1:0]    n);
      logic [GFULL_W-1:0] g;
      logic [G_W-1:0]     lim;
      logic [G_W-1:0]     gc;
      logic [N_W-1:0]     top;
      logic [N_W-1:0]     cell_idx;
      logic [G_W-1:0]     frac;
      g        = prod[PROD_W-1:SCALE_SHIFT];
      lim      = {n, {FRAC_BITS{1'b0}}};
      gc       = (g > GFULL_W'(lim)) ? lim : G_W'(g);
      top      = n - N_W'(1);
      cell_idx = (gc[G_W-1:FRAC_BITS] > top) ? top : gc[G_W-1:FRAC_BITS];
      frac     = gc - {cell_idx, {FRAC_BITS{1'b0}}};
      return {cell_idx, frac[TX_W-1:0]};
   endfunction

   hbs_ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic adv1, adv2, adv3, adv4;
   logic accept;

   logic [ADDR_W-1:0]       s1_addr_ff, s2_addr_ff, s3_addr_ff, s4_addr_ff;
   logic [HEIGHT_WIDTH-1:0] s1_wdata_ff, s2_wdata_ff, s3_wdata_ff, s4_wdata_ff;
   logic [POS_W-1:0]        s1_px_ff, s1_pz_ff;
   logic [N_W-1:0]          s1_n_ff, s2_n_ff;
   logic [PROD_W-1:0]       s2_prod_x_ff, s2_prod_z_ff;
   logic [N_W-1:0]          s3_i0_ff, s3_j0_ff;
   logic [TX_W-1:0]         s3_tx_ff, s3_tz_ff, s4_tx_ff, s4_tz_ff;
   logic [V_W-1:0]          s3_step_ff, s4_step_ff;

   logic signed [P_W-1:0]   px_sum, pz_sum;
   logic [POS_W-1:0]        px_pos, pz_pos;
   logic [N_W-1:0]          n_in;
   hbs_ctl_type             s1_ctl_in;
   logic [SPLIT_W-1:0]      split_x, split_z;
   logic [ADDR_W-1:0]       base_addr;

   // stage k takes new contents when it is empty or its contents move on
   assign adv4   = ~s4_ctl_ff.valid | item_ready;
   assign adv3   = ~s3_ctl_ff.valid | adv4;
   assign adv2   = ~s2_ctl_ff.valid | adv3;
   assign adv1   = ~s1_ctl_ff.valid | adv2;
   assign busy   = ~adv1;
   assign accept = start & adv1;

   assign px_sum = P_W'(req_pos_x) + $signed(P_W'(half_size));
   assign pz_sum = P_W'(req_pos_z) + $signed(P_W'(half_size));
   assign px_pos = (~px_sum[P_W-1] && (px_sum != '0)) ? px_sum[POS_W-1:0] : '0;
   assign pz_pos = (~pz_sum[P_W-1] && (pz_sum != '0)) ? pz_sum[POS_W-1:0] : '0;

   assign n_in = (32'(grid_cells) > 32'(GRID_MAX)) ? N_W'(GRID_MAX) : N_W'(grid_cells);

   always_comb begin
      s1_ctl_in.valid    = accept;
      s1_ctl_in.is_write = (req_func == FUNC_WRITE);
      s1_ctl_in.wr_ok    = (32'(req_sample_index) < 32'(DEPTH));
      s1_ctl_in.empty    = (grid_cells == '0) | (inv_cell == '0);
   end

   assign split_x   = split_coord(s2_prod_x_ff, s2_n_ff);
   assign split_z   = split_coord(s2_prod_z_ff, s2_n_ff);
   assign base_addr = ADDR_W'(s3_j0_ff) * ADDR_W'(s3_step_ff) + ADDR_W'(s3_i0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else begin
         if (adv1) s1_ctl_ff <= s1_ctl_in;
         if (adv2) s2_ctl_ff <= s1_ctl_ff;
         if (adv3) s3_ctl_ff <= s2_ctl_ff;
         if (adv4) s4_ctl_ff <= s3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_addr_ff  <= ADDR_W'(req_sample_index);
         s1_wdata_ff <= HEIGHT_WIDTH'($unsigned(req_height_value));
         s1_px_ff    <= px_pos;
         s1_pz_ff    <= pz_pos;
         s1_n_ff     <= n_in;
      end
      if (adv2) begin
         s2_addr_ff   <= s1_addr_ff;
         s2_wdata_ff  <= s1_wdata_ff;
         s2_n_ff      <= s1_n_ff;
         s2_prod_x_ff <= PROD_W'(s1_px_ff) * PROD_W'(inv_cell);
         s2_prod_z_ff <= PROD_W'(s1_pz_ff) * PROD_W'(inv_cell);
      end
      if (adv3) begin
         s3_addr_ff  <= s2_addr_ff;
         s3_wdata_ff <= s2_wdata_ff;
         s3_i0_ff    <= split_x[SPLIT_W-1:TX_W];
         s3_tx_ff    <= split_x[TX_W-1:0];
         s3_j0_ff    <= split_z[SPLIT_W-1:TX_W];
         s3_tz_ff    <= split_z[TX_W-1:0];
         s3_step_ff  <= V_W'(s2_n_ff) + V_W'(1);
      end
      if (adv4) begin
         s4_addr_ff  <= s3_ctl_ff.is_write ? s3_addr_ff : base_addr;
         s4_wdata_ff <= s3_wdata_ff;
         s4_tx_ff    <= s3_tx_ff;
         s4_tz_ff    <= s3_tz_ff;
         s4_step_ff  <= s3_step_ff;
      end
   end

   assign item_ctl   = s4_ctl_ff;
   assign item_addr  = s4_addr_ff;
   assign item_wdata = s4_wdata_ff;
   assign item_step  = s4_step_ff;
   assign item_tx    = s4_tx_ff;
   assign item_tz    = s4_tz_ff;

endmodule

[src/hbs_store.sv]
// ============================================================================
// hbs_store - height memory and corner read sequencer
// Single-port synchronous RAM. A write uses the port once, a query once per
// cell corner. Read data and a corner tag come out in the cycle after each read.
// ============================================================================
module hbs_store import hbs_pkg::*; #(
   parameter int GRID_MAX     = GRID_MAX_DEF,
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hbs_ctl_type                   item_ctl,
   input  logic [$clog2((GRID_MAX+1)*(GRID_MAX+1))-1:0] item_addr,
   input  logic [HEIGHT_WIDTH-1:0]       item_wdata,
   input  logic [$clog2(GRID_MAX+2)-1:0] item_step,
   input  logic [FRAC_BITS:0]            item_tx,
   input  logic [FRAC_BITS:0]            item_tz,
   output logic                          item_ready,
   output hbs_tag_type                   rd_tag,
   output logic [HEIGHT_WIDTH-1:0]       rd_data,
   output logic [FRAC_BITS:0]            rd_tx,
   output logic [FRAC_BITS:0]            rd_tz
);

   localparam int DEPTH  = (GRID_MAX + 1) * (GRID_MAX + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int V_W    = $clog2(GRID_MAX + 2);
   localparam int TX_W   = FRAC_BITS + 1;

   logic [HEIGHT_WIDTH-1:0] mem [DEPTH];

   hbs_ctl_type             m_ctl_ff, m_ctl_in;
   corner_type              corner_ff, corner_in;
   logic [ADDR_W-1:0]       m_addr_ff;
   logic [HEIGHT_WIDTH-1:0] m_wdata_ff;
   logic [V_W-1:0]          m_step_ff;
   logic [TX_W-1:0]         m_tx_ff, m_tz_ff;
   hbs_tag_type             rd_tag_ff;
   logic [HEIGHT_WIDTH-1:0] rd_data_ff;
   logic [TX_W-1:0]         rd_tx_ff, rd_tz_ff;
   logic                    m_done;
   logic                    mem_we;
   logic [ADDR_W-1:0]       offset;
   logic [ADDR_W-1:0]       mem_addr;

   assign m_done     = m_ctl_ff.valid & (m_ctl_ff.is_write | (corner_ff == CORNER_11));
   assign item_ready = ~m_ctl_ff.valid | m_done;
   assign m_ctl_in   = item_ready ? item_ctl : m_ctl_ff;
   assign corner_in  = item_ready ? CORNER_00 : corner_type'(corner_ff + 2'd1);

   always_comb begin
      case (corner_ff)
         CORNER_00: offset = '0;
         CORNER_10: offset = ADDR_W'(1);
         CORNER_01: offset = ADDR_W'(m_step_ff);
         CORNER_11: offset = ADDR_W'(m_step_ff) + ADDR_W'(1);
         default:   offset = '0;
      endcase
   end

   // writes always sit at CORNER_00, so the same address path serves both
   assign mem_addr = m_addr_ff + offset;
   assign mem_we   = m_ctl_ff.valid & m_ctl_ff.is_write & m_ctl_ff.wr_ok;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= m_wdata_ff;
      end else begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ctl_ff  <= '0;
         corner_ff <= CORNER_00;
         rd_tag_ff <= '0;
      end else begin
         m_ctl_ff         <= m_ctl_in;
         corner_ff        <= corner_in;
         rd_tag_ff.valid  <= m_ctl_ff.valid & ~m_ctl_ff.is_write;
         rd_tag_ff.corner <= corner_ff;
         rd_tag_ff.empty  <= m_ctl_ff.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (item_ready) begin
         m_addr_ff  <= item_addr;
         m_wdata_ff <= item_wdata;
         m_step_ff  <= item_step;
         m_tx_ff    <= item_tx;
         m_tz_ff    <= item_tz;
      end
      rd_tx_ff <= m_tx_ff;
      rd_tz_ff <= m_tz_ff;
   end

   assign rd_tag  = rd_tag_ff;
   assign rd_data = rd_data_ff;
   assign rd_tx   = rd_tx_ff;
   assign rd_tz   = rd_tz_ff;

endmodule

[src/hbs_lerp.sv]
// ============================================================================
// hbs_lerp - bilinear interpolator
// Consumes corner heights as they stream from the store and forms
// a = lerp(h00,h10,tx), b = lerp(h01,h11,tx), result = lerp(a,b,tz).
// ============================================================================
module hbs_lerp import hbs_pkg::*; #(
   parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hbs_tag_type             rd_tag,
   input  logic [HEIGHT_WIDTH-1:0] rd_data,
   input  logic [FRAC_BITS:0]      rd_tx,
   input  logic [FRAC_BITS:0]      rd_tz,
   output logic                    rsp_strobe,
   output logic signed [OUT_W-1:0] rsp_height
);

   localparam int TX_W = FRAC_BITS + 1;
   localparam int D_W  = HEIGHT_WIDTH + 1;
   localparam int LP_W = HEIGHT_WIDTH + TX_W + 2;

   logic signed [HEIGHT_WIDTH-1:0] q;
   logic signed [HEIGHT_WIDTH-1:0] h00_ff, h01_ff, a_ff, a2_ff, a3_ff, b_ff;
   logic signed [LP_W-1:0]         pa_ff, pb_ff, pr_ff;
   logic [TX_W-1:0]                tz_pb_ff, tz2_ff;
   logic                           empty_pb_ff, empty2_ff, empty3_ff;
   logic                           pb_v_ff, b_v_ff, r_v_ff, rsp_strobe_ff;
   logic [OUT_W-1:0]               rsp_height_ff;

   logic signed [D_W-1:0]          diff_lo, diff_hi, diff_r;
   logic signed [TX_W:0]           tx_s, tz_s;
   logic signed [LP_W-1:0]         pa_in, pb_in, pr_in;
   logic signed [LP_W-1:0]         a_sum, b_sum, r_sum;

   assign q       = $signed(rd_data);
   assign tx_s    = $signed({1'b0, rd_tx});
   assign tz_s    = $signed({1'b0, tz2_ff});
   assign diff_lo = D_W'(q) - D_W'(h00_ff);
   assign diff_hi = D_W'(q) - D_W'(h01_ff);
   assign diff_r  = D_W'(b_ff) - D_W'(a2_ff);
   assign pa_in   = LP_W'(diff_lo) * LP_W'(tx_s);
   assign pb_in   = LP_W'(diff_hi) * LP_W'(tx_s);
   assign pr_in   = LP_W'(diff_r) * LP_W'(tz_s);

   // arithmetic shift gives the floor of the weighted difference
   assign a_sum = LP_W'(h00_ff) + (pa_ff >>> FRAC_BITS);
   assign b_sum = LP_W'(h01_ff) + (pb_ff >>> FRAC_BITS);
   assign r_sum = LP_W'(a3_ff) + (pr_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_v_ff       <= 1'b0;
         b_v_ff        <= 1'b0;
         r_v_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pb_v_ff       <= rd_tag.valid & (rd_tag.corner == CORNER_11);
         b_v_ff        <= pb_v_ff;
         r_v_ff        <= b_v_ff;
         rsp_strobe_ff <= r_v_ff;
      end
   end

   // a_ff and h01_ff hold until the next query's third corner
   always_ff @(posedge clock) begin
      if (rd_tag.valid) begin
         case (rd_tag.corner)
            CORNER_00: h00_ff <= q;
            CORNER_10: pa_ff <= pa_in;
            CORNER_01: begin
               h01_ff <= q;
               a_ff   <= a_sum[HEIGHT_WIDTH-1:0];
            end
            CORNER_11: begin
               pb_ff       <= pb_in;
               tz_pb_ff    <= rd_tz;
               empty_pb_ff <= rd_tag.empty;
            end
            default: ;
         endcase
      end
      b_ff          <= b_sum[HEIGHT_WIDTH-1:0];
      a2_ff         <= a_ff;
      tz2_ff        <= tz_pb_ff;
      empty2_ff     <= empty_pb_ff;
      pr_ff         <= pr_in;
      a3_ff         <= a2_ff;
      empty3_ff     <= empty2_ff;
      rsp_height_ff <= empty3_ff ? '0 : OUT_W'(r_sum[HEIGHT_WIDTH-1:0]);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_height = $signed(rsp_height_ff);

endmodule
